@@ rtl/rfc_pkg.sv @@
// Shared types and constants for the reciprocal frequency counter.
// Used by rfc_ctrl, rfc_dp and reciprocal_frequency_counter; no dependencies.
`default_nettype none

package rfc_pkg;

    // Field widths
    localparam int OP_W     = 2;
    localparam int CAP_W    = 16;
    localparam int CLK_W    = 24;
    localparam int TPER_W   = 17;
    localparam int FREQ_W   = 24;
    localparam int DIG_W    = 4;
    localparam int DIGITS   = 4;
    localparam int CNT_W    = $clog2(FREQ_W);

    // Overflow counter width default
    localparam int OVF_BITS_DEF = 16;

    // Register reset values
    localparam logic [CLK_W-1:0]  CLK_RESET  = 24'd8000000;
    localparam logic [TPER_W-1:0] TPER_RESET = 17'd80;

    // Divide by ten: exact for values below 2**26
    localparam logic [FREQ_W-1:0] DIV10_MUL   = 24'd13421773;
    localparam int                DIV10_SHIFT = 27;

    // APB register map
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_CLOCK = 1'b0;
    localparam logic REG_TPER  = 1'b1;

    // Operation codes
    typedef logic [OP_W-1:0] t_op;
    localparam t_op OP_CAPTURE  = 2'd0;
    localparam t_op OP_OVERFLOW = 2'd1;
    localparam t_op OP_DISPLAY  = 2'd2;

    // Result kinds
    localparam logic KIND_FREQ   = 1'b0;
    localparam logic KIND_DIGITS = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CHK,
        S_DIV,
        S_DMUL,
        S_DSUB,
        S_OUT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic arm;
        logic ovf_inc;
        logic load_cap;
        logic mul;
        logic chk;
        logic div_step;
        logic disp_init;
        logic dig_mul;
        logic dig_sub;
        logic out_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic armed;
        logic err;
        logic cnt_zero;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ rtl/reciprocal_frequency_counter.sv @@
// Capture edge: multiply, check, 24 divide steps, then the output load; a bad period
// skips the divide steps and goes straight to the output load. Display request: four
// digit splits (multiply, then subtract), then the output load. Overflow and the
// arming edge are handled in the idle state; the output load waits for a free register.
// One word is in work at a time; the 24-step restoring divider sets the capture rate.
// Synchronous active-low reset restores register defaults and disarms the block.
`default_nettype none

module reciprocal_frequency_counter #(
    parameter int OVERFLOW_BITS = rfc_pkg::OVF_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // APB configuration
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire [rfc_pkg::APB_AW-1:0]       paddr,
    input  wire [rfc_pkg::APB_DW-1:0]       pwdata,
    output logic [rfc_pkg::APB_DW-1:0]      prdata,
    output logic                            pready,
    // input words
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire [rfc_pkg::OP_W-1:0]         i_operation,
    input  wire [rfc_pkg::CAP_W-1:0]        i_capture_value,
    // result words
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic                            o_kind,
    output logic [rfc_pkg::FREQ_W-1:0]      o_frequency_hz,
    output logic                            o_period_error,
    output logic [rfc_pkg::DIG_W-1:0]       o_digit_thousands,
    output logic [rfc_pkg::DIG_W-1:0]       o_digit_hundreds,
    output logic [rfc_pkg::DIG_W-1:0]       o_digit_tens,
    output logic [rfc_pkg::DIG_W-1:0]       o_digit_units,
    output logic                            o_show_frequency
);

    logic [rfc_pkg::CLK_W-1:0]  r_count_clock_hz;
    logic [rfc_pkg::TPER_W-1:0] r_timer_period;
    logic                       w_wr;
    rfc_pkg::t_cmd              w_cmd;
    rfc_pkg::t_sts              w_sts;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_clock_hz <= rfc_pkg::CLK_RESET;
            r_timer_period   <= rfc_pkg::TPER_RESET;
        end else if (w_wr) begin
            unique case (paddr[2])
                rfc_pkg::REG_CLOCK: r_count_clock_hz <= pwdata[rfc_pkg::CLK_W-1:0];
                rfc_pkg::REG_TPER:  r_timer_period   <= pwdata[rfc_pkg::TPER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            rfc_pkg::REG_CLOCK: prdata = rfc_pkg::APB_DW'(r_count_clock_hz);
            rfc_pkg::REG_TPER:  prdata = rfc_pkg::APB_DW'(r_timer_period);
            default:            prdata = '0;
        endcase
    end

    rfc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_sts       (w_sts),
        .o_in_ready  (o_in_ready),
        .o_cmd       (w_cmd)
    );

    rfc_dp #(
        .OVERFLOW_BITS (OVERFLOW_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_capture_value   (i_capture_value),
        .i_count_clock_hz  (r_count_clock_hz),
        .i_timer_period    (r_timer_period),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_kind            (o_kind),
        .o_frequency_hz    (o_frequency_hz),
        .o_period_error    (o_period_error),
        .o_digit_thousands (o_digit_thousands),
        .o_digit_hundreds  (o_digit_hundreds),
        .o_digit_tens      (o_digit_tens),
        .o_digit_units     (o_digit_units),
        .o_show_frequency  (o_show_frequency)
    );

`ifndef SYNTH
    // a frequency word carries no digits
    a_freq_no_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == rfc_pkg::KIND_FREQ)) |->
        (o_digit_thousands == '0 && o_digit_hundreds == '0 &&
         o_digit_tens == '0 && o_digit_units == '0))
        else $error("frequency word with nonzero digits");

    // a digit word never flags a period error
    a_digits_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == rfc_pkg::KIND_DIGITS)) |-> !o_period_error)
        else $error("digit word with period error");

    // digits stay decimal
    a_digits_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_digit_thousands <= 4'd9 && o_digit_hundreds <= 4'd9 &&
                         o_digit_tens <= 4'd9 && o_digit_units <= 4'd9))
        else $error("digit out of decimal range");

    // a display request occupies the block for its digit split
    a_display_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_operation == rfc_pkg::OP_DISPLAY)) |=>
        !o_in_ready)
        else $error("input taken during digit split");
`endif

endmodule

`default_nettype wire

@@ rtl/rfc_ctrl.sv @@
// Sequencing state machine for the reciprocal frequency counter.
// Depends on rfc_pkg; drives rfc_dp through t_cmd and reads t_sts.
`default_nettype none

module rfc_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire rfc_pkg::t_op   i_operation,
    input  wire rfc_pkg::t_sts  i_sts,
    output logic                o_in_ready,
    output rfc_pkg::t_cmd       o_cmd
);

    rfc_pkg::t_state r_state;
    rfc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rfc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            rfc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_operation)
                        rfc_pkg::OP_CAPTURE: begin
                            if (!i_sts.armed) begin
                                o_cmd.arm = 1'b1;
                            end else begin
                                o_cmd.load_cap = 1'b1;
                                n_state        = rfc_pkg::S_MUL;
                            end
                        end
                        rfc_pkg::OP_OVERFLOW: begin
                            o_cmd.ovf_inc = 1'b1;
                        end
                        rfc_pkg::OP_DISPLAY: begin
                            o_cmd.disp_init = 1'b1;
                            n_state         = rfc_pkg::S_DMUL;
                        end
                        default: begin
                            // unused code: drop the word
                        end
                    endcase
                end
            end
            rfc_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = rfc_pkg::S_CHK;
            end
            rfc_pkg::S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = rfc_pkg::S_DIV;
            end
            rfc_pkg::S_DIV: begin
                if (i_sts.err) begin
                    n_state = rfc_pkg::S_OUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (i_sts.cnt_zero) begin
                        n_state = rfc_pkg::S_OUT;
                    end
                end
            end
            rfc_pkg::S_DMUL: begin
                o_cmd.dig_mul = 1'b1;
                n_state       = rfc_pkg::S_DSUB;
            end
            rfc_pkg::S_DSUB: begin
                o_cmd.dig_sub = 1'b1;
                n_state       = i_sts.cnt_zero ? rfc_pkg::S_OUT : rfc_pkg::S_DMUL;
            end
            rfc_pkg::S_OUT: begin
                // hold until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = rfc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rfc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/rfc_dp.sv @@
// Datapath: measurement state, period multiplier, restoring divider,
// decimal digit split and the output register. Depends on rfc_pkg.
`default_nettype none

module rfc_dp #(
    parameter int OVERFLOW_BITS = rfc_pkg::OVF_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire rfc_pkg::t_cmd              i_cmd,
    output rfc_pkg::t_sts                   o_sts,
    input  wire [rfc_pkg::CAP_W-1:0]        i_capture_value,
    input  wire [rfc_pkg::CLK_W-1:0]        i_count_clock_hz,
    input  wire [rfc_pkg::TPER_W-1:0]       i_timer_period,
    input  wire                             i_out_ready,
    output logic                            o_out_valid,
    output logic                            o_kind,
    output logic [rfc_pkg::FREQ_W-1:0]      o_frequency_hz,
    output logic                            o_period_error,
    output logic [rfc_pkg::DIG_W-1:0]       o_digit_thousands,
    output logic [rfc_pkg::DIG_W-1:0]       o_digit_hundreds,
    output logic [rfc_pkg::DIG_W-1:0]       o_digit_tens,
    output logic [rfc_pkg::DIG_W-1:0]       o_digit_units,
    output logic                            o_show_frequency
);

    localparam int PRW  = OVERFLOW_BITS + rfc_pkg::TPER_W;  // overflow ticks
    localparam int PW   = PRW + 1;                          // period
    localparam int FW   = rfc_pkg::FREQ_W;
    localparam int DW   = rfc_pkg::DIG_W;
    localparam int QW   = 2 * FW - rfc_pkg::DIV10_SHIFT;
    localparam int DVW  = rfc_pkg::DIGITS * DW;

    // Measurement state
    logic                       r_armed;
    logic [rfc_pkg::CAP_W-1:0]  r_start;
    logic [OVERFLOW_BITS-1:0]   r_ovf;
    logic [FW-1:0]              r_latest;
    logic                       r_show;

    // Working registers
    logic [rfc_pkg::CAP_W-1:0]  r_cap;
    logic [PRW-1:0]             r_prod;
    logic [PW-1:0]              r_per;
    logic [PW-1:0]              r_rem;
    logic [FW-1:0]              r_quo;
    logic                       r_err;
    logic                       r_kind;
    logic [rfc_pkg::CNT_W-1:0]  r_cnt;
    logic [FW-1:0]              r_work;
    logic [2*FW-1:0]            r_dprod;
    logic [DVW-1:0]             r_digits;

    // Output register
    logic                       r_out_valid;
    logic                       r_o_kind;
    logic [FW-1:0]              r_o_freq;
    logic                       r_o_err;
    logic [DVW-1:0]             r_o_digits;
    logic                       r_o_show;

    logic [PW-1:0]              w_sum;
    logic                       w_bad;
    logic [PW:0]                w_trial;
    logic                       w_ge;
    logic [PW:0]                w_trial_sub;
    logic [QW-1:0]              w_q;
    logic [FW-1:0]              w_qx10;
    logic [FW-1:0]              w_dig;

    // Period = overflow ticks + end - start; bad when not above zero
    assign w_sum = PW'(r_prod) + PW'(r_cap);
    assign w_bad = (w_sum <= PW'(r_start));

    // One restoring division step: shift in the next dividend bit
    assign w_trial     = {r_rem, r_quo[FW-1]};
    assign w_ge        = (w_trial >= {1'b0, r_per});
    assign w_trial_sub = w_trial - {1'b0, r_per};

    // Split off one decimal digit
    assign w_q    = r_dprod[rfc_pkg::DIV10_SHIFT +: QW];
    assign w_qx10 = FW'({w_q, 3'b000}) + FW'({w_q, 1'b0});
    assign w_dig  = r_work - w_qx10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= 1'b0;
            r_start     <= '0;
            r_ovf       <= '0;
            r_latest    <= '0;
            r_show      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.arm) begin
                r_armed <= 1'b1;
                r_start <= i_capture_value;
                r_ovf   <= '0;
            end
            if (i_cmd.ovf_inc && (r_ovf != {OVERFLOW_BITS{1'b1}})) begin
                r_ovf <= r_ovf + 1'b1;
            end
            if (i_cmd.chk) begin
                r_start <= r_cap;
                r_ovf   <= '0;
            end
            if (i_cmd.div_step && (r_cnt == '0)) begin
                r_latest <= {r_quo[FW-2:0], w_ge};
            end
            if (i_cmd.disp_init) begin
                r_show <= ~r_show;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_cap) begin
            r_cap  <= i_capture_value;
            r_kind <= rfc_pkg::KIND_FREQ;
        end
        if (i_cmd.mul) begin
            r_prod <= PRW'(r_ovf) * PRW'(i_timer_period);
        end
        if (i_cmd.chk) begin
            r_err <= w_bad;
            r_per <= w_sum - PW'(r_start);
            r_rem <= '0;
            r_quo <= i_count_clock_hz;
            r_cnt <= rfc_pkg::CNT_W'(FW - 1);
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_trial_sub[PW-1:0] : w_trial[PW-1:0];
            r_quo <= {r_quo[FW-2:0], w_ge};
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.disp_init) begin
            r_kind <= rfc_pkg::KIND_DIGITS;
            r_err  <= 1'b0;
            r_work <= r_latest;
            r_cnt  <= rfc_pkg::CNT_W'(rfc_pkg::DIGITS - 1);
        end
        if (i_cmd.dig_mul) begin
            r_dprod <= r_work * rfc_pkg::DIV10_MUL;
        end
        if (i_cmd.dig_sub) begin
            // units come out first and end up in the low nibble
            r_work   <= FW'(w_q);
            r_digits <= {w_dig[DW-1:0], r_digits[DVW-1:DW]};
            r_cnt    <= r_cnt - 1'b1;
        end
        if (i_cmd.out_load) begin
            r_o_kind   <= r_kind;
            r_o_freq   <= r_latest;
            r_o_err    <= r_err;
            r_o_digits <= (r_kind == rfc_pkg::KIND_DIGITS) ? r_digits : '0;
            r_o_show   <= r_show;
        end
    end

    assign o_sts.armed    = r_armed;
    assign o_sts.err      = r_err;
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_kind            = r_o_kind;
    assign o_frequency_hz    = r_o_freq;
    assign o_period_error    = r_o_err;
    assign o_digit_units     = r_o_digits[0*DW +: DW];
    assign o_digit_tens      = r_o_digits[1*DW +: DW];
    assign o_digit_hundreds  = r_o_digits[2*DW +: DW];
    assign o_digit_thousands = r_o_digits[3*DW +: DW];
    assign o_show_frequency  = r_o_show;

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking bench for reciprocal_frequency_counter: directed table, then random words
// under several register settings, checked against a cycle-free behavioral predictor.
// Depends on rfc_pkg and the reciprocal_frequency_counter RTL.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          OVF_BITS     = rfc_pkg::OVF_BITS_DEF;
    localparam int          MAX_IDLE     = 10;
    localparam int          SETTLE       = 40;
    localparam int          PHASE_WORDS  = 190;
    localparam int          LONG_BURST   = 20;
    localparam int          CYCLE_LIMIT  = 2_000_000;
    localparam rfc_pkg::t_op OP_UNUSED   = 2'd3;
    localparam logic [rfc_pkg::APB_AW-1:0] ADDR_CLOCK = {rfc_pkg::REG_CLOCK, 2'b00};
    localparam logic [rfc_pkg::APB_AW-1:0] ADDR_TPER  = {rfc_pkg::REG_TPER, 2'b00};

    typedef struct packed {
        logic                       kind;
        logic [rfc_pkg::FREQ_W-1:0] freq;
        logic                       err;
        logic [rfc_pkg::DIG_W-1:0]  thou;
        logic [rfc_pkg::DIG_W-1:0]  hund;
        logic [rfc_pkg::DIG_W-1:0]  tens;
        logic [rfc_pkg::DIG_W-1:0]  units;
        logic                       show;
    } t_reading;

    typedef struct packed {
        rfc_pkg::t_op              op;
        logic [rfc_pkg::CAP_W-1:0] cap;
        logic                      fixed;
        t_reading                  want;
    } t_stim_row;

    typedef struct packed {
        logic        rand_pick;
        logic [31:0] clk_val;
        logic [31:0] tper_val;
    } t_reg_setting;

    localparam t_reading R_RESET_DISPLAY =
        '{rfc_pkg::KIND_DIGITS, 24'd0, 1'b0, 4'd0, 4'd0, 4'd0, 4'd0, 1'b1};
    localparam t_reading R_ZERO_PERIOD =
        '{rfc_pkg::KIND_FREQ, 24'd0, 1'b1, 4'd0, 4'd0, 4'd0, 4'd0, 1'b1};
    localparam t_reading R_ONE_KHZ =
        '{rfc_pkg::KIND_FREQ, 24'd1000, 1'b0, 4'd0, 4'd0, 4'd0, 4'd0, 1'b1};
    localparam t_reading R_ONE_KHZ_DIGITS =
        '{rfc_pkg::KIND_DIGITS, 24'd1000, 1'b0, 4'd1, 4'd0, 4'd0, 4'd0, 1'b0};

    // Directed words run with the reset register values (8 MHz clock, period 80).
    localparam int N_DIRECTED = 21;
    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        '{rfc_pkg::OP_DISPLAY,  16'h0000, 1'b1, R_RESET_DISPLAY},
        '{rfc_pkg::OP_OVERFLOW, 16'hFFFF, 1'b0, '0},
        '{OP_UNUSED,            16'hFFFF, 1'b0, '0},
        '{rfc_pkg::OP_CAPTURE,  16'h0000, 1'b0, '0},
        '{rfc_pkg::OP_CAPTURE,  16'h0000, 1'b1, R_ZERO_PERIOD},
        '{rfc_pkg::OP_CAPTURE,  16'd8000, 1'b1, R_ONE_KHZ},
        '{rfc_pkg::OP_DISPLAY,  16'h0000, 1'b1, R_ONE_KHZ_DIGITS},
        '{rfc_pkg::OP_CAPTURE,  16'd7999, 1'b0, '0},
        '{rfc_pkg::OP_OVERFLOW, 16'h0000, 1'b0, '0},
        '{rfc_pkg::OP_OVERFLOW, 16'h0000, 1'b0, '0},
        '{rfc_pkg::OP_CAPTURE,  16'hFFFF, 1'b0, '0},
        '{OP_UNUSED,            16'h5555, 1'b0, '0},
        '{rfc_pkg::OP_CAPTURE,  16'h0000, 1'b0, '0},
        '{rfc_pkg::OP_CAPTURE,  16'h0001, 1'b0, '0},
        '{rfc_pkg::OP_DISPLAY,  16'hAAAA, 1'b0, '0},
        '{rfc_pkg::OP_OVERFLOW, 16'h5555, 1'b0, '0},
        '{rfc_pkg::OP_CAPTURE,  16'h0001, 1'b0, '0},
        '{rfc_pkg::OP_CAPTURE,  16'd8009, 1'b0, '0},
        '{rfc_pkg::OP_DISPLAY,  16'h0000, 1'b0, '0},
        '{rfc_pkg::OP_CAPTURE,  16'hFFFF, 1'b0, '0},
        '{rfc_pkg::OP_DISPLAY,  16'h0000, 1'b0, '0}
    };

    localparam int N_SETTINGS = 8;
    localparam t_reg_setting REG_PLAN [N_SETTINGS] = '{
        '{1'b0, 32'd1,          32'd1},
        '{1'b0, 32'hFFFF_FFFF,  32'hFFFF_FFFF},
        '{1'b0, 32'd0,          32'd0},
        '{1'b0, 32'd16777215,   32'd65536},
        '{1'b0, 32'd1000000,    32'd1000},
        '{1'b1, 32'd0,          32'd0},
        '{1'b1, 32'd0,          32'd0},
        '{1'b0, 32'd8000000,    32'd80}
    };

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [rfc_pkg::APB_AW-1:0]   paddr = '0;
    logic [rfc_pkg::APB_DW-1:0]   pwdata = '0;
    logic [rfc_pkg::APB_DW-1:0]   prdata;
    logic                         pready;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [rfc_pkg::OP_W-1:0]     in_operation = '0;
    logic [rfc_pkg::CAP_W-1:0]    in_capture = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic                         out_kind;
    logic [rfc_pkg::FREQ_W-1:0]   out_freq;
    logic                         out_err;
    logic [rfc_pkg::DIG_W-1:0]    out_thou, out_hund, out_tens, out_units;
    logic                         out_show;

    // predictor state and register copies
    logic                         meter_armed = 1'b0;
    logic [rfc_pkg::CAP_W-1:0]    start_stamp = '0;
    logic [OVF_BITS-1:0]          ovf_count = '0;
    logic [rfc_pkg::FREQ_W-1:0]   latest_hz = '0;
    logic                         show_flag = 1'b0;
    logic [rfc_pkg::CLK_W-1:0]    clk_hz = rfc_pkg::CLK_RESET;
    logic [rfc_pkg::TPER_W-1:0]   tper_ticks = rfc_pkg::TPER_RESET;

    t_reading    pending_readings [$];
    int unsigned mismatches = 0;
    int unsigned words_sent = 0;
    int unsigned readings_checked = 0;
    int unsigned cycle_count = 0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;

    reciprocal_frequency_counter #(.OVERFLOW_BITS(OVF_BITS)) DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_operation      (in_operation),
        .i_capture_value  (in_capture),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_kind           (out_kind),
        .o_frequency_hz   (out_freq),
        .o_period_error   (out_err),
        .o_digit_thousands(out_thou),
        .o_digit_hundreds (out_hund),
        .o_digit_tens     (out_tens),
        .o_digit_units    (out_units),
        .o_show_frequency (out_show)
    );

    always #10 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d readings outstanding",
                     cycle_count, pending_readings.size());
            $display("reciprocal_frequency_counter regression: fail");
            $finish;
        end
    end

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Advance the meter by one word; return 1 when the word yields a reading.
    function automatic bit measure_step(input rfc_pkg::t_op op,
                                        input logic [rfc_pkg::CAP_W-1:0] cap,
                                        output t_reading rd);
        longint period;
        rd = '0;
        case (op)
            rfc_pkg::OP_CAPTURE: begin
                if (!meter_armed) begin
                    meter_armed = 1'b1;
                    start_stamp = cap;
                    ovf_count = '0;
                    return 1'b0;
                end
                period = longint'(cap) + longint'(ovf_count) * longint'(tper_ticks)
                       - longint'(start_stamp);
                if (period <= 0)
                    rd.err = 1'b1;
                else
                    latest_hz = rfc_pkg::FREQ_W'(longint'(clk_hz) / period);
                start_stamp = cap;
                ovf_count = '0;
                rd.kind = rfc_pkg::KIND_FREQ;
                rd.freq = latest_hz;
                rd.show = show_flag;
                return 1'b1;
            end
            rfc_pkg::OP_OVERFLOW: begin
                if (ovf_count != {OVF_BITS{1'b1}})
                    ovf_count = ovf_count + 1'b1;
                return 1'b0;
            end
            rfc_pkg::OP_DISPLAY: begin
                show_flag = ~show_flag;
                rd.kind = rfc_pkg::KIND_DIGITS;
                rd.freq = latest_hz;
                rd.thou = rfc_pkg::DIG_W'((latest_hz / 1000) % 10);
                rd.hund = rfc_pkg::DIG_W'((latest_hz / 100) % 10);
                rd.tens = rfc_pkg::DIG_W'((latest_hz / 10) % 10);
                rd.units = rfc_pkg::DIG_W'(latest_hz % 10);
                rd.show = show_flag;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic send_word(input rfc_pkg::t_op op, input logic [rfc_pkg::CAP_W-1:0] cap,
                             input logic fixed, input t_reading want);
        int unsigned gap;
        t_reading rd;
        gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_operation <= op;
        in_capture <= cap;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
        if (measure_step(op, cap, rd))
            pending_readings.push_back(fixed ? want : rd);
    endtask

    // Drop valid and hold until every expected reading is back.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_readings.size() > 0) @(posedge clk);
    endtask

    // Drain, then let a word with no reading finish before touching registers.
    task automatic settle();
        hold_until_drained();
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic reg_write(input logic [rfc_pkg::APB_AW-1:0] addr,
                             input logic [rfc_pkg::APB_DW-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_CLOCK)
            clk_hz = data[rfc_pkg::CLK_W-1:0];
        else
            tper_ticks = data[rfc_pkg::TPER_W-1:0];
        @(posedge clk);
    endtask

    task automatic reg_read(input logic [rfc_pkg::APB_AW-1:0] addr,
                            input logic [rfc_pkg::APB_DW-1:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        check_field(addr == ADDR_CLOCK ? "prdata count_clock_hz" : "prdata timer_period",
                    want, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly capture runs with short overflow bursts and display requests; a tail of
    // unused codes and random operations as noise.
    task automatic random_phase(input int unsigned count);
        int unsigned sent;
        int unsigned pick;
        rfc_pkg::t_op op;
        logic [rfc_pkg::CAP_W-1:0] cap;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            cap = rfc_pkg::CAP_W'($urandom_range(0, 65535));
            if (pick < 50) begin
                op = rfc_pkg::OP_CAPTURE;
                if (pick < 5)
                    cap = start_stamp;
                else if (pick < 30)
                    cap = start_stamp + rfc_pkg::CAP_W'($urandom_range(1, 3000));
            end else if (pick < 72) begin
                op = rfc_pkg::OP_OVERFLOW;
            end else if (pick < 92) begin
                op = rfc_pkg::OP_DISPLAY;
            end else if (pick < 97) begin
                op = OP_UNUSED;
            end else begin
                op = rfc_pkg::t_op'($urandom_range(0, 3));
            end
            send_word(op, cap, 1'b0, '0);
            if (op != OP_UNUSED)
                sent++;
            if ($urandom_range(0, 199) == 0)
                hold_until_drained();
        end
    endtask

    initial begin : reading_sink
        t_reading got;
        t_reading want;
        int unsigned stall;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            got = {out_kind, out_freq, out_err, out_thou, out_hund, out_tens, out_units,
                   out_show};
            if (pending_readings.size() == 0) begin
                $error("reading arrived with none expected: kind %0d freq %0d",
                       got.kind, got.freq);
                mismatches++;
            end else begin
                want = pending_readings.pop_front();
                readings_checked++;
                check_field("kind", want.kind, got.kind);
                check_field("frequency_hz", want.freq, got.freq);
                check_field("period_error", want.err, got.err);
                check_field("digit_thousands", want.thou, got.thou);
                check_field("digit_hundreds", want.hund, got.hund);
                check_field("digit_tens", want.tens, got.tens);
                check_field("digit_units", want.units, got.units);
                check_field("show_frequency", want.show, got.show);
            end
        end
    end

    initial begin : stimulus
        logic [31:0] clk_val;
        logic [31:0] tper_val;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        reg_read(ADDR_CLOCK, rfc_pkg::APB_DW'(rfc_pkg::CLK_RESET));
        reg_read(ADDR_TPER, rfc_pkg::APB_DW'(rfc_pkg::TPER_RESET));

        for (int i = 0; i < N_DIRECTED; i++)
            send_word(DIRECTED[i].op, DIRECTED[i].cap, DIRECTED[i].fixed, DIRECTED[i].want);
        random_phase(PHASE_WORDS);

        for (int ph = 0; ph < N_SETTINGS; ph++) begin
            settle();
            clk_val = REG_PLAN[ph].clk_val;
            tper_val = REG_PLAN[ph].tper_val;
            if (REG_PLAN[ph].rand_pick) begin
                clk_val = $urandom_range(1, 16777215);
                tper_val = $urandom_range(1, 65536);
            end
            reg_write(ADDR_CLOCK, clk_val);
            reg_write(ADDR_TPER, tper_val);
            reg_read(ADDR_CLOCK, rfc_pkg::APB_DW'(clk_hz));
            reg_read(ADDR_TPER, rfc_pkg::APB_DW'(tper_ticks));
            tx_idle = (ph % 3 != 1);
            rx_idle = (ph % 3 != 2) && (ph != 4);
            random_phase(PHASE_WORDS);
        end

        // Long overflow burst under the widest clock setting and a timer period of 65536.
        settle();
        reg_write(ADDR_CLOCK, 32'd16777215);
        reg_write(ADDR_TPER, 32'd65536);
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        send_word(rfc_pkg::OP_CAPTURE, 16'h0000, 1'b0, '0);
        send_word(rfc_pkg::OP_CAPTURE, 16'h0000, 1'b0, '0);
        repeat (LONG_BURST)
            send_word(rfc_pkg::OP_OVERFLOW, rfc_pkg::CAP_W'($urandom_range(0, 65535)),
                      1'b0, '0);
        send_word(rfc_pkg::OP_CAPTURE, 16'd100, 1'b0, '0);
        send_word(rfc_pkg::OP_DISPLAY, 16'h0000, 1'b0, '0);

        settle();
        $display("sent %0d words and checked %0d readings across %0d register settings",
                 words_sent, readings_checked, N_SETTINGS + 2);
        $display("covered arming, bad periods, display toggles, unused codes, zero clock");
        if (mismatches == 0)
            $display("reciprocal_frequency_counter regression: pass");
        else
            $display("reciprocal_frequency_counter regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/rfc_pkg.sv
rtl/rfc_ctrl.sv
rtl/rfc_dp.sv
rtl/reciprocal_frequency_counter.sv
verif/testbench.sv
